// ----- src/ptyp_pkg.sv -----
// Shared constants, types and tables for the point to yaw/pitch pipeline.
`default_nettype none
package ptyp_pkg;

    // field formats
    localparam int COORD_WIDTH     = 24;
    localparam int COEF_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int COEF_W          = 16;
    localparam int TRANS_W         = 21;
    localparam int ROW_W           = 3 * COEF_W;
    localparam int TRANS_REG_W     = 3 * TRANS_W;
    localparam int CFG_DATA_W      = TRANS_REG_W;
    localparam int CFG_IDX_W       = 3;
    localparam int YAW_W           = 16;
    localparam int PITCH_W         = 15;

    // transform widths
    localparam int PROD_W  = COEF_W + COORD_WIDTH;
    localparam int TTERM_W = TRANS_W + COEF_FRAC_BITS;
    localparam int C_W     = PROD_W + 2;
    localparam int MAG_W   = C_W - 1;
    localparam int POS_W   = $clog2(MAG_W);

    // normalization and root
    localparam int NORM_W   = 30;
    localparam int NORM_MSB = NORM_W - 1;
    localparam int SQ_W     = 2 * NORM_W + 1;
    localparam int ROOT_W   = (SQ_W + 1) / 2;

    // CORDIC
    localparam int CORDIC_STEPS = 28;
    localparam int XY_W         = NORM_W + 4;
    localparam int Z_W          = 32;
    localparam int Q_FRAC       = 24;
    localparam int ANG_SH       = Q_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] DEG_90  = Z_W'(longint'(90) << Q_FRAC);
    localparam logic [Z_W-1:0]        DEG_180 = Z_W'(longint'(180) << Q_FRAC);
    localparam logic [Z_W-1:0]        RND_HALF = Z_W'(longint'(1) << (ANG_SH - 1));

    // atan(2^-i) in 2^-24 degree
    localparam logic signed [Z_W-1:0] ATAN_Q24 [CORDIC_STEPS] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7
    };

    // stage counts
    localparam int XF_LAT    = 3;
    localparam int NRM_LAT   = 2;
    localparam int HYP_LAT   = 2 + ROOT_W;
    localparam int COR_LAT   = CORDIC_STEPS + 2;
    localparam int YAW_DLY   = NRM_LAT + HYP_LAT;
    localparam int PSIGN_DLY = 2 * NRM_LAT + HYP_LAT;
    localparam int N0_DLY    = HYP_LAT;
    localparam int DEGEN_DLY = 2 * NRM_LAT + HYP_LAT + COR_LAT;
    localparam int PIPE_LAT  = XF_LAT + DEGEN_DLY + 1;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW0    = 3'd0,
        REG_ROT_ROW1    = 3'd1,
        REG_ROT_ROW2    = 3'd2,
        REG_TRANSLATION = 3'd3
    } t_reg_idx;

    localparam logic [ROW_W-1:0]       ROT_ROW0_RST = ROW_W'(longint'(16384));
    localparam logic [ROW_W-1:0]       ROT_ROW1_RST = ROW_W'(longint'(16384) << COEF_W);
    localparam logic [ROW_W-1:0]       ROT_ROW2_RST = ROW_W'(longint'(16384) << (2 * COEF_W));
    localparam logic [TRANS_REG_W-1:0] TRANS_RST    = '0;

    // sign and zero flags of the transformed point
    typedef struct packed {
        logic neg0;
        logic pos1;
        logic neg2;
        logic zero;
    } t_xf_flags;

endpackage
`default_nettype wire

// ----- src/point_to_yaw_pitch_core.sv -----
// Top level: point to yaw/pitch pipeline with config registers and handshakes.
`default_nettype none
// Takes one Q11.12 point (x, y, z) per request, forms c = R*p + t with the
// configured Q2.14 rotation rows and offsets, and returns yaw = atan2(c2, -c1)
// and pitch = atan2(c0, sqrt(c1^2 + c2^2)) in 1/128 degree. A point that maps
// exactly to the origin comes back with the degenerate flag set and both
// angles zero. The block accepts one request every cycle while the result
// side does not stall; the result timing is set by the 31-stage square root
// of the pitch path followed by the 28-step CORDIC pipeline. A stall on the
// result side freezes the whole pipeline; a one-entry skid buffer at the
// input keeps o_in_stall a registered signal.
// Configuration writes are always ready and should only be made while no
// request is in flight. Index 0..2 are rotation rows, 3 the translation;
// other indices are ignored.
module point_to_yaw_pitch_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // request side
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic signed [ptyp_pkg::COORD_WIDTH-1:0]   i_point_x,
    input  logic signed [ptyp_pkg::COORD_WIDTH-1:0]   i_point_y,
    input  logic signed [ptyp_pkg::COORD_WIDTH-1:0]   i_point_z,
    // result side
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [ptyp_pkg::YAW_W-1:0]         o_yaw_angle,
    output logic signed [ptyp_pkg::PITCH_W-1:0]       o_pitch_angle,
    output logic                                      o_degenerate,
    // configuration writes
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [ptyp_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [ptyp_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import ptyp_pkg::*;

    // ---------------- configuration registers ----------------
    logic [ROW_W-1:0]       r_rot [3];
    logic [TRANS_REG_W-1:0] r_trans;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= ROT_ROW0_RST;
            r_rot[1] <= ROT_ROW1_RST;
            r_rot[2] <= ROT_ROW2_RST;
            r_trans  <= TRANS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ROT_ROW0:    r_rot[0] <= i_cfg_data[ROW_W-1:0];
                REG_ROT_ROW1:    r_rot[1] <= i_cfg_data[ROW_W-1:0];
                REG_ROT_ROW2:    r_rot[2] <= i_cfg_data[ROW_W-1:0];
                REG_TRANSLATION: r_trans  <= i_cfg_data[TRANS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input skid and pipeline enable ----------------
    logic                          r_vld [PIPE_LAT];
    logic                          w_en;
    logic                          w_acc;
    logic                          r_skid_vld;
    logic signed [COORD_WIDTH-1:0] r_skid_p [3];
    logic signed [COORD_WIDTH-1:0] w_src_p [3];
    logic                          w_src_vld;

    // whole pipeline holds while the finished result is refused
    assign w_en       = !(r_vld[PIPE_LAT-1] && i_out_stall);
    assign o_in_stall = r_skid_vld;
    assign w_acc      = i_in_valid && !r_skid_vld;
    assign w_src_vld  = r_skid_vld || w_acc;

    always_comb begin
        if (r_skid_vld) begin
            w_src_p = r_skid_p;
        end else begin
            w_src_p[0] = i_point_x;
            w_src_p[1] = i_point_y;
            w_src_p[2] = i_point_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            r_skid_vld <= 1'b0;
        end else if (w_acc) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && !w_en) begin
            r_skid_p[0] <= i_point_x;
            r_skid_p[1] <= i_point_y;
            r_skid_p[2] <= i_point_z;
        end
    end

    // valid bits march alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_src_vld;
            for (int k = 1; k < PIPE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- transform ----------------
    logic [MAG_W-1:0] w_mag [3];
    t_xf_flags        w_flags;

    ptyp_xform u_xform (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_rot   (r_rot),
        .i_trans (r_trans),
        .i_p     (w_src_p),
        .o_mag   (w_mag),
        .o_flags (w_flags)
    );

    // ---------------- yaw path ----------------
    logic [NORM_W-1:0]       w_yaw_y, w_yaw_x, w_yaw_unused;
    logic                    r_yaw_yn [NRM_LAT];
    logic                    r_yaw_xn [NRM_LAT];
    logic signed [YAW_W-1:0] w_yaw_ang;
    logic signed [YAW_W-1:0] r_yaw_dly [YAW_DLY];

    ptyp_norm u_yaw_norm (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_mag[2]),
        .i_b   (w_mag[1]),
        .i_c   ('0),
        .o_a   (w_yaw_y),
        .o_b   (w_yaw_x),
        .o_c   (w_yaw_unused)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yaw_yn[0] <= w_flags.neg2;
            r_yaw_xn[0] <= w_flags.pos1;
            for (int k = 1; k < NRM_LAT; k++) begin
                r_yaw_yn[k] <= r_yaw_yn[k-1];
                r_yaw_xn[k] <= r_yaw_xn[k-1];
            end
        end
    end

    ptyp_cordic u_yaw_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (w_yaw_x),
        .i_y     (w_yaw_y),
        .i_xneg  (r_yaw_xn[NRM_LAT-1]),
        .i_yneg  (r_yaw_yn[NRM_LAT-1]),
        .o_angle (w_yaw_ang)
    );

    // yaw waits for the longer pitch path
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yaw_dly[0] <= w_yaw_ang;
            for (int k = 1; k < YAW_DLY; k++) begin
                r_yaw_dly[k] <= r_yaw_dly[k-1];
            end
        end
    end

    // ---------------- pitch path ----------------
    logic [NORM_W-1:0]       w_n0, w_n1, w_n2;
    logic [ROOT_W-1:0]       w_h;
    logic [NORM_W-1:0]       r_n0_dly [N0_DLY];
    logic                    r_p_yn [PSIGN_DLY];
    logic [NORM_W-1:0]       w_p_y, w_p_x, w_p_unused;
    logic signed [YAW_W-1:0] w_pitch_ang;

    ptyp_norm u_pitch_norm (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_mag[0]),
        .i_b   (w_mag[1]),
        .i_c   (w_mag[2]),
        .o_a   (w_n0),
        .o_b   (w_n1),
        .o_c   (w_n2)
    );

    ptyp_hyp u_hyp (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (w_n1),
        .i_y    (w_n2),
        .o_root (w_h)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n0_dly[0] <= w_n0;
            for (int k = 1; k < N0_DLY; k++) begin
                r_n0_dly[k] <= r_n0_dly[k-1];
            end
            r_p_yn[0] <= w_flags.neg0;
            for (int k = 1; k < PSIGN_DLY; k++) begin
                r_p_yn[k] <= r_p_yn[k-1];
            end
        end
    end

    // second normalization on (|c0|, h) before the pitch CORDIC
    ptyp_norm u_pitch_norm2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (MAG_W'(r_n0_dly[N0_DLY-1])),
        .i_b   (MAG_W'(w_h)),
        .i_c   ('0),
        .o_a   (w_p_y),
        .o_b   (w_p_x),
        .o_c   (w_p_unused)
    );

    ptyp_cordic u_pitch_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (w_p_x),
        .i_y     (w_p_y),
        .i_xneg  (1'b0),
        .i_yneg  (r_p_yn[PSIGN_DLY-1]),
        .o_angle (w_pitch_ang)
    );

    // ---------------- degenerate flag and output register ----------------
    logic                      r_zero_dly [DEGEN_DLY];
    logic signed [YAW_W-1:0]   r_out_yaw;
    logic signed [PITCH_W-1:0] r_out_pitch;
    logic                      r_out_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero_dly[0] <= w_flags.zero;
            for (int k = 1; k < DEGEN_DLY; k++) begin
                r_zero_dly[k] <= r_zero_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_degen <= r_zero_dly[DEGEN_DLY-1];
            if (r_zero_dly[DEGEN_DLY-1]) begin
                r_out_yaw   <= '0;
                r_out_pitch <= '0;
            end else begin
                r_out_yaw   <= r_yaw_dly[YAW_DLY-1];
                r_out_pitch <= w_pitch_ang[PITCH_W-1:0];
            end
        end
    end

    assign o_out_valid   = r_vld[PIPE_LAT-1];
    assign o_yaw_angle   = r_out_yaw;
    assign o_pitch_angle = r_out_pitch;
    assign o_degenerate  = r_out_degen;

    // ---------------- assertions ----------------
    a_skid_only_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(!w_en))
        else $error("skid buffer filled while the pipeline was moving");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |-> (o_yaw_angle == '0 && o_pitch_angle == '0))
        else $error("degenerate result with nonzero angles");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch_angle >= -15'sd11520 && o_pitch_angle <= 15'sd11520))
        else $error("pitch outside +-90 degrees");

endmodule
`default_nettype wire

// ----- src/ptyp_xform.sv -----
// Rigid transform c = R*p + t in three stages, giving magnitudes and signs.
`default_nettype none
module ptyp_xform (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [ptyp_pkg::ROW_W-1:0]              i_rot [3],
    input  logic [ptyp_pkg::TRANS_REG_W-1:0]        i_trans,
    input  logic signed [ptyp_pkg::COORD_WIDTH-1:0] i_p [3],
    output logic [ptyp_pkg::MAG_W-1:0]              o_mag [3],
    output ptyp_pkg::t_xf_flags                     o_flags
);
    import ptyp_pkg::*;

    logic signed [PROD_W-1:0]  r_prod [3][3];
    logic signed [TTERM_W-1:0] r_tterm [3];
    logic signed [C_W-1:0]     r_c [3];
    logic [MAG_W-1:0]          r_mag [3];
    t_xf_flags                 r_flags;

    // products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[r][j] <= $signed(i_rot[r][COEF_W*j +: COEF_W]) * i_p[j];
                end
                r_tterm[r] <= {i_trans[TRANS_W*r +: TRANS_W], {COEF_FRAC_BITS{1'b0}}};
            end
        end
    end

    // row sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_c[r] <= C_W'(r_prod[r][0]) + C_W'(r_prod[r][1])
                        + C_W'(r_prod[r][2]) + C_W'(r_tterm[r]);
            end
        end
    end

    // magnitudes and flags
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_mag[r] <= r_c[r][C_W-1] ? MAG_W'(-r_c[r]) : MAG_W'(r_c[r]);
            end
            r_flags.neg0 <= r_c[0][C_W-1];
            r_flags.pos1 <= !r_c[1][C_W-1] && (r_c[1] != '0);
            r_flags.neg2 <= r_c[2][C_W-1];
            r_flags.zero <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        end
    end

    assign o_mag   = r_mag;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

// ----- src/ptyp_norm.sv -----
// Common block shift: largest of three magnitudes lands in [2^29, 2^30).
`default_nettype none
module ptyp_norm (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ptyp_pkg::MAG_W-1:0]  i_a,
    input  logic [ptyp_pkg::MAG_W-1:0]  i_b,
    input  logic [ptyp_pkg::MAG_W-1:0]  i_c,
    output logic [ptyp_pkg::NORM_W-1:0] o_a,
    output logic [ptyp_pkg::NORM_W-1:0] o_b,
    output logic [ptyp_pkg::NORM_W-1:0] o_c
);
    import ptyp_pkg::*;

    logic [MAG_W-1:0]  w_or;
    logic [POS_W-1:0]  w_pos;
    logic [MAG_W-1:0]  r_a, r_b, r_c;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  w_dn, w_up;
    logic              w_right;
    logic [NORM_W-1:0] r_oa, r_ob, r_oc;

    // leading one of the OR equals that of the maximum
    always_comb begin
        w_or  = i_a | i_b | i_c;
        w_pos = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (w_or[k]) begin
                w_pos = POS_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_c   <= i_c;
            r_pos <= w_pos;
        end
    end

    always_comb begin
        w_right = r_pos > POS_W'(NORM_MSB);
        w_dn    = r_pos - POS_W'(NORM_MSB);
        w_up    = POS_W'(NORM_MSB) - r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_right) begin
                r_oa <= NORM_W'(r_a >> w_dn);
                r_ob <= NORM_W'(r_b >> w_dn);
                r_oc <= NORM_W'(r_c >> w_dn);
            end else begin
                r_oa <= NORM_W'(r_a << w_up);
                r_ob <= NORM_W'(r_b << w_up);
                r_oc <= NORM_W'(r_c << w_up);
            end
        end
    end

    assign o_a = r_oa;
    assign o_b = r_ob;
    assign o_c = r_oc;

endmodule
`default_nettype wire

// ----- src/ptyp_hyp.sv -----
// floor(sqrt(x^2 + y^2)): squares, sum, then one root bit per stage.
`default_nettype none
module ptyp_hyp (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ptyp_pkg::NORM_W-1:0] i_x,
    input  logic [ptyp_pkg::NORM_W-1:0] i_y,
    output logic [ptyp_pkg::ROOT_W-1:0] o_root
);
    import ptyp_pkg::*;

    localparam int TW = SQ_W + 2;

    logic [2*NORM_W-1:0] r_sx, r_sy;
    logic [SQ_W-1:0]     r_sum;
    logic [SQ_W-1:0]     w_rem_in [ROOT_W];
    logic [ROOT_W-1:0]   w_q_in   [ROOT_W];
    logic [SQ_W-1:0]     r_rem    [ROOT_W];
    logic [ROOT_W-1:0]   r_q      [ROOT_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx  <= i_x * i_x;
            r_sy  <= i_y * i_y;
            r_sum <= SQ_W'(r_sx) + SQ_W'(r_sy);
        end
    end

    genvar s;
    generate
        for (s = 0; s < ROOT_W; s++) begin : g_root
            localparam int K = ROOT_W - 1 - s;
            logic [TW-1:0] w_trial;
            logic          w_take;

            if (s == 0) begin : g_first
                assign w_rem_in[s] = r_sum;
                assign w_q_in[s]   = '0;
            end else begin : g_next
                assign w_rem_in[s] = r_rem[s-1];
                assign w_q_in[s]   = r_q[s-1];
            end

            // (q + 2^K)^2 - q^2 = q*2^(K+1) + 4^K
            always_comb begin
                w_trial = (TW'(w_q_in[s]) << (K + 1)) | (TW'(1) << (2 * K));
                w_take  = TW'(w_rem_in[s]) >= w_trial;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_take) begin
                        r_rem[s] <= SQ_W'(TW'(w_rem_in[s]) - w_trial);
                        r_q[s]   <= w_q_in[s] | (ROOT_W'(1) << K);
                    end else begin
                        r_rem[s] <= w_rem_in[s];
                        r_q[s]   <= w_q_in[s];
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_q[ROOT_W-1];

endmodule
`default_nettype wire

// ----- src/ptyp_cordic.sv -----
// Pipelined CORDIC vectoring, one step per stage, then quadrant fix and rounding.
`default_nettype none
module ptyp_cordic (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [ptyp_pkg::NORM_W-1:0]       i_x,
    input  logic [ptyp_pkg::NORM_W-1:0]       i_y,
    input  logic                              i_xneg,
    input  logic                              i_yneg,
    output logic signed [ptyp_pkg::YAW_W-1:0] o_angle
);
    import ptyp_pkg::*;

    logic signed [XY_W-1:0] w_x_in [CORDIC_STEPS];
    logic signed [XY_W-1:0] w_y_in [CORDIC_STEPS];
    logic signed [Z_W-1:0]  w_z_in [CORDIC_STEPS];
    logic                   w_xn_in [CORDIC_STEPS];
    logic                   w_yn_in [CORDIC_STEPS];
    logic signed [XY_W-1:0] r_x [CORDIC_STEPS];
    logic signed [XY_W-1:0] r_y [CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z [CORDIC_STEPS];
    logic                   r_xn [CORDIC_STEPS];
    logic                   r_yn [CORDIC_STEPS];

    logic signed [Z_W-1:0]  w_zl;
    logic [Z_W-1:0]         w_zc;
    logic [Z_W-1:0]         r_zm;
    logic                   r_fyn;
    logic [YAW_W-1:0]       w_mag;
    logic signed [YAW_W-1:0] r_ang;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            if (i == 0) begin : g_first
                assign w_x_in[i]  = XY_W'(i_x);
                assign w_y_in[i]  = XY_W'(i_y);
                assign w_z_in[i]  = '0;
                assign w_xn_in[i] = i_xneg;
                assign w_yn_in[i] = i_yneg;
            end else begin : g_next
                assign w_x_in[i]  = r_x[i-1];
                assign w_y_in[i]  = r_y[i-1];
                assign w_z_in[i]  = r_z[i-1];
                assign w_xn_in[i] = r_xn[i-1];
                assign w_yn_in[i] = r_yn[i-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_y_in[i] > 0) begin
                        r_x[i] <= w_x_in[i] + (w_y_in[i] >>> i);
                        r_y[i] <= w_y_in[i] - (w_x_in[i] >>> i);
                        r_z[i] <= w_z_in[i] + ATAN_Q24[i];
                    end else begin
                        r_x[i] <= w_x_in[i] - (w_y_in[i] >>> i);
                        r_y[i] <= w_y_in[i] + (w_x_in[i] >>> i);
                        r_z[i] <= w_z_in[i] - ATAN_Q24[i];
                    end
                    r_xn[i] <= w_xn_in[i];
                    r_yn[i] <= w_yn_in[i];
                end
            end
        end
    endgenerate

    // clamp to [0, 90] deg, mirror into the left half plane
    always_comb begin
        w_zl = r_z[CORDIC_STEPS-1];
        if (w_zl < 0) begin
            w_zc = '0;
        end else if (w_zl > DEG_90) begin
            w_zc = DEG_90;
        end else begin
            w_zc = w_zl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zm  <= r_xn[CORDIC_STEPS-1] ? DEG_180 - w_zc : w_zc;
            r_fyn <= r_yn[CORDIC_STEPS-1];
        end
    end

    // round half away from zero on the magnitude
    assign w_mag = YAW_W'((r_zm + RND_HALF) >> ANG_SH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= r_fyn ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_angle = r_ang;

endmodule
`default_nettype wire

// ----- sim/tb_point_to_yaw_pitch_core.sv -----
// Testbench for the point to yaw/pitch pipeline: self-checking, random and directed requests.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected angle results in order and compares each returned result.
class angle_scoreboard;
    logic [15:0] exp_yaw [$];
    logic [14:0] exp_pitch [$];
    logic        exp_degen [$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function void note_request(logic [15:0] yaw, logic [14:0] pitch, logic degen);
        exp_yaw.push_back(yaw);
        exp_pitch.push_back(pitch);
        exp_degen.push_back(degen);
    endfunction

    function void check_result(logic [15:0] yaw, logic [14:0] pitch, logic degen);
        logic [15:0] ey;
        logic [14:0] ep;
        logic        ed;
        if (exp_yaw.size() == 0) begin
            $display("%0t: unexpected result yaw=%0d pitch=%0d degen=%0b",
                     $time, $signed(yaw), $signed(pitch), degen);
            errors++;
            return;
        end
        ey = exp_yaw.pop_front();
        ep = exp_pitch.pop_front();
        ed = exp_degen.pop_front();
        if (yaw !== ey) begin
            $display("%0t: yaw expected %0d actual %0d", $time, $signed(ey), $signed(yaw));
            errors++;
        end
        if (pitch !== ep) begin
            $display("%0t: pitch expected %0d actual %0d", $time, $signed(ep),
                     $signed(pitch));
            errors++;
        end
        if (degen !== ed) begin
            $display("%0t: degenerate expected %0b actual %0b", $time, ed, degen);
            errors++;
        end
    endfunction

    function int pending();
        return exp_yaw.size();
    endfunction
endclass

module tb_point_to_yaw_pitch_core;
    import ptyp_pkg::*;

    localparam longint Q24_ONE = 64'sd1 << 24;
    localparam int     TIMEOUT_CYCLES = 400000;

    localparam longint ATAN_TBL [28] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [COORD_WIDTH-1:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [YAW_W-1:0] o_yaw_angle;
    logic signed [PITCH_W-1:0] o_pitch_angle;
    logic o_degenerate;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    point_to_yaw_pitch_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of the transform registers.
    logic [ROW_W-1:0]       rot_m [3];
    logic [TRANS_REG_W-1:0] offs_m;

    angle_scoreboard sb = new();

    // Idle and stall rates in percent; the hold-off overrides the stall.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    longint cycle_cnt = 0;

    // ---- predictor ----

    // Vectoring CORDIC on magnitudes, result in 2^-24 degree.
    function automatic longint atan2_deg24(bit yneg, longint unsigned ay, bit xneg,
                                           longint unsigned ax);
        longint x, y, z, dx, dy;
        z = 0;
        if (ay == 0 && ax == 0) return 0;
        while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
            ax >>= 1;
            ay >>= 1;
        end
        while (ax < (64'd1 << 29) && ay < (64'd1 << 29)) begin
            ax <<= 1;
            ay <<= 1;
        end
        x = longint'(ax);
        y = longint'(ay);
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 90 * Q24_ONE) z = 90 * Q24_ONE;
        if (xneg) z = 180 * Q24_ONE - z;
        if (yneg) z = -z;
        return z;
    endfunction

    // Round 2^-24 degree to the output grid, halves away from zero.
    function automatic longint round_angle(longint z);
        longint unsigned m;
        longint r;
        m = (z < 0) ? longint'(-z) : z;
        r = longint'((m + (64'd1 << (ANG_SH - 1))) >> ANG_SH);
        return (z < 0) ? -r : r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Expected angles for one point under the current transform.
    task automatic predict_angles(input logic signed [COORD_WIDTH-1:0] px, py, pz);
        longint p [3], c [3], acc;
        longint unsigned n0, n1, n2, mx, h;
        logic signed [COEF_W-1:0] coef;
        logic signed [TRANS_W-1:0] tv;
        longint yaw, pitch;
        p[0] = px; p[1] = py; p[2] = pz;
        for (int r = 0; r < 3; r++) begin
            tv = offs_m[TRANS_W*r +: TRANS_W];
            acc = longint'(tv) * (64'sd1 << COEF_FRAC_BITS);
            for (int j = 0; j < 3; j++) begin
                coef = rot_m[r][COEF_W*j +: COEF_W];
                acc += longint'(coef) * p[j];
            end
            c[r] = acc;
        end
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            sb.note_request('0, '0, 1'b1);
            return;
        end
        yaw = round_angle(atan2_deg24(c[2] < 0, abs64(c[2]), c[1] > 0, abs64(c[1])));
        n0 = abs64(c[0]); n1 = abs64(c[1]); n2 = abs64(c[2]);
        mx = (n0 > n1) ? n0 : n1;
        if (n2 > mx) mx = n2;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1; n0 >>= 1; n1 >>= 1; n2 >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1; n0 <<= 1; n1 <<= 1; n2 <<= 1;
        end
        h = int_sqrt(n1 * n1 + n2 * n2);
        pitch = round_angle(atan2_deg24(c[0] < 0, n0, 1'b0, h));
        sb.note_request(yaw[15:0], pitch[14:0], 1'b0);
    endtask

    // ---- drivers ----

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ROT_ROW0:    rot_m[0] = val[ROW_W-1:0];
            REG_ROT_ROW1:    rot_m[1] = val[ROW_W-1:0];
            REG_ROT_ROW2:    rot_m[2] = val[ROW_W-1:0];
            REG_TRANSLATION: offs_m = val;
            default: ;
        endcase
    endtask

    // Offer one point, with a random idle gap before it at the current rate.
    task automatic send_point(input logic signed [COORD_WIDTH-1:0] px, py, pz);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x  <= px;
        i_point_y  <= py;
        i_point_z  <= pz;
        do @(posedge i_clk); while (o_in_stall);
        predict_angles(px, py, pz);
    endtask

    // Drop valid after the last request of a burst.
    task automatic go_quiet();
        i_in_valid <= 1'b0;
    endtask

    // Wait until all results are back, then let the pipeline drain.
    task automatic wait_drained();
        go_quiet();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(5))
            0: return COORD_WIDTH'(int'($urandom_range(7)) - 4);
            1: return COORD_WIDTH'(int'($urandom_range(8191)) - 4096);
            2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        logic [ROW_W-1:0] v;
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(3))
                0: v[16*j +: 16] = 16'h0000;
                1: v[16*j +: 16] = $urandom_range(1) ? 16'h7fff : 16'h8000;
                default: v[16*j +: 16] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [TRANS_REG_W-1:0] rand_offs();
        logic [TRANS_REG_W-1:0] v;
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(3))
                0: v[21*j +: 21] = '0;
                1: v[21*j +: 21] = $urandom_range(1) ? 21'h0fffff : 21'h100000;
                default: v[21*j +: 21] = 21'($urandom);
            endcase
        end
        return v;
    endfunction

    // Random burst of points at the current idle rates.
    task automatic random_burst(input int n);
        for (int k = 0; k < n; k++) send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    // ---- result side ----

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // A result is taken on this edge if valid and we were not stalling.
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_yaw_angle, o_pitch_angle, o_degenerate);
            i_out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("** point_to_yaw_pitch_core: FAILED **");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process.
    task automatic long_hold();
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    initial begin
        rot_m[0] = ROT_ROW0_RST;
        rot_m[1] = ROT_ROW1_RST;
        rot_m[2] = ROT_ROW2_RST;
        offs_m   = TRANS_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity transform, axes, extremes, origin, straight up/down.
        send_point(0, 0, 0);
        send_point(24'sh7fffff, 0, 0);
        send_point(24'sh800000, 0, 0);
        send_point(0, 24'sh7fffff, 0);
        send_point(0, 24'sh800000, 0);
        send_point(0, 0, 24'sh7fffff);
        send_point(0, 0, 24'sh800000);
        send_point(0, 1, -1);
        send_point(0, 1000, -1);
        send_point(5, -3, 0);
        send_point(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        send_point(24'sh800000, 24'sh800000, 24'sh800000);
        send_point(24'sh555555, 24'shaaaaaa, 24'sh123456);
        send_point(1, 1, 1);
        send_point(-1, -1, -1);
        wait_drained();

        // Extreme transform: full-scale coefficients and offsets.
        write_reg(REG_ROT_ROW0, CFG_DATA_W'({16'h7fff, 16'h8000, 16'h7fff}));
        write_reg(REG_ROT_ROW1, CFG_DATA_W'({16'h8000, 16'h7fff, 16'h8000}));
        write_reg(REG_ROT_ROW2, CFG_DATA_W'({16'h7fff, 16'h7fff, 16'h8000}));
        write_reg(REG_TRANSLATION, {21'h0fffff, 21'h100000, 21'h0fffff});
        // Unknown index is ignored.
        write_reg(t_reg_idx'(3'd6), '1);
        send_point(0, 0, 0);
        send_point(24'sh7fffff, 24'sh800000, 24'sh7fffff);
        send_point(24'sh800000, 24'sh7fffff, 24'sh800000);
        random_burst(20);
        wait_drained();

        // Translation cancelling the point: origin from a nonzero input.
        write_reg(REG_ROT_ROW0, CFG_DATA_W'(ROT_ROW0_RST));
        write_reg(REG_ROT_ROW1, CFG_DATA_W'(ROT_ROW1_RST));
        write_reg(REG_ROT_ROW2, CFG_DATA_W'(ROT_ROW2_RST));
        write_reg(REG_TRANSLATION, {21'd0, 21'd0, 21'd100});
        send_point(-100, 0, 0);
        send_point(-100, 0, 3);
        wait_drained();

        // Random phases: each with a fresh transform and its own idle mix.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(REG_ROT_ROW0, CFG_DATA_W'(rand_row()));
            write_reg(REG_ROT_ROW1, CFG_DATA_W'(rand_row()));
            write_reg(REG_ROT_ROW2, CFG_DATA_W'(rand_row()));
            write_reg(REG_TRANSLATION, rand_offs());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (ph == 4) begin
                // Receiver holds off while the sender keeps offering.
                fork
                    long_hold();
                    random_burst(100);
                join
            end else begin
                random_burst(95);
            end
            wait_drained();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** point_to_yaw_pitch_core: PASSED **");
        else
            $display("** point_to_yaw_pitch_core: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
src/ptyp_pkg.sv
src/ptyp_xform.sv
src/ptyp_norm.sv
src/ptyp_hyp.sv
src/ptyp_cordic.sv
src/point_to_yaw_pitch_core.sv
sim/tb_point_to_yaw_pitch_core.sv
